@@ design/bfa_pkg.sv @@
`timescale 1ns / 1ps

package bfa_pkg;

  // field widths
  localparam int ADDR_W   = 32;
  localparam int SIZE_W   = 28;
  localparam int COUNT_W  = 16;
  localparam int ACT_W    = 2;
  localparam int STATUS_W = 2;
  localparam int INDEX_W  = 1;

  // map geometry
  localparam int MAX_FRAMES = 32768;
  localparam int PAGE_BYTES = 4096;
  localparam int WORD_BITS  = 32;
  localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;

  localparam int WADDR_W = $clog2(MAP_WORDS);
  localparam int BIT_W   = $clog2(WORD_BITS);
  localparam int PAGE_SH = $clog2(PAGE_BYTES);
  localparam int FI_W    = $clog2(MAX_FRAMES);      // frame index
  localparam int CNT_W   = FI_W + 1;                // frame count, holds MAX_FRAMES
  localparam int LW_W    = CNT_W - BIT_W;           // word count
  localparam int FIDX_W  = ADDR_W - PAGE_SH;        // index taken from an address
  localparam int N_W     = SIZE_W + 1 - PAGE_SH;    // frames in a range

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0010_0000;

  // actions
  localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_MARK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_INIT  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  // register indexes
  localparam logic [INDEX_W-1:0] REG_BASE_ADDRESS = 1'b0;
  localparam logic [INDEX_W-1:0] REG_FRAME_COUNT  = 1'b1;

endpackage

@@ design/bfa_ram.sv @@
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ design/bitmap_frame_allocator.sv @@
`timescale 1ns / 1ps

// bitmap page-frame allocator: one bit per frame (1 used, 0 free) held in a
// 1024 x 32 synchronous ram; frame i sits at base_address + i * 4096.
// a request is taken when start is high and busy is low; its single result
// appears on frame_address and status for exactly one cycle with done high,
// and must be taken then. after reset the block runs a clearing pass over all
// 1024 map words, with busy high, that marks every frame used; configuration
// writes are taken at any time, but only while idle do they take effect in a
// defined way. the single ram read/write port pair sets the pace: allocate
// reads map words in order up to the first free frame and writes that word
// back, or reads every managed word when none is free; free reads and writes
// one word; mark used reads then writes each map word touched; a request
// settled without touching the map (ignored, empty range, nothing managed)
// ends after the decision; initialize writes every map word. busy drops in
// the cycle that done is high, so the next request may follow at once.

module bitmap_frame_allocator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           write_enable,
  input  logic [bfa_pkg::INDEX_W-1:0]    write_index,
  input  logic [bfa_pkg::ADDR_W-1:0]     write_data,
  input  logic                           start,
  output logic                           busy,
  input  logic [bfa_pkg::ACT_W-1:0]      action,
  input  logic [bfa_pkg::ADDR_W-1:0]     address,
  input  logic [bfa_pkg::SIZE_W-1:0]     size_bytes,
  output logic                           done,
  output logic [bfa_pkg::ADDR_W-1:0]     frame_address,
  output logic [bfa_pkg::STATUS_W-1:0]   status
);

  import bfa_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_PREP      = 9'b000000010,
    S_DECIDE    = 9'b000000100,
    S_SCAN      = 9'b000001000,
    S_ALLOC_FIN = 9'b000010000,
    S_FREE_WR   = 9'b000100000,
    S_MARK_RD   = 9'b001000000,
    S_MARK_WR   = 9'b010000000,
    S_FILL      = 9'b100000000
  } state_t;

  // bits of word w whose frame index lies below lim
  function automatic logic [WORD_BITS-1:0] upper_mask(input logic [WADDR_W-1:0] w,
                                                      input logic [CNT_W-1:0] lim);
    logic [LW_W-1:0] lw;
    lw = lim[CNT_W-1:BIT_W];
    if (LW_W'(w) < lw) begin
      return '1;
    end else if (LW_W'(w) == lw) begin
      return ~({WORD_BITS{1'b1}} << lim[BIT_W-1:0]);
    end else begin
      return '0;
    end
  endfunction

  // configuration registers
  logic [ADDR_W-1:0]  base_address;
  logic [COUNT_W-1:0] frame_limit;

  // control
  state_t state, state_next;
  logic   fill_reset;

  // captured request
  logic [ACT_W-1:0]  act_q;
  logic [ADDR_W-1:0] addr_q;
  logic [SIZE_W-1:0] size_q;

  // prepared operands
  logic [CNT_W-1:0]  cnt_q;
  logic [LW_W-1:0]   nwords_q;
  logic [FIDX_W-1:0] idx_q;
  logic [N_W-1:0]    n_q;
  logic              below_q;
  logic              misalign_q;
  logic [CNT_W-1:0]  lo_q;
  logic [CNT_W-1:0]  hi_q;

  // walkers
  logic [WADDR_W-1:0] wptr;
  logic [LW_W-1:0]    rd_ptr;
  logic [WADDR_W-1:0] chk_word;
  logic               rd_valid;
  logic [FI_W-1:0]    hit_idx;

  // ram ports
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WADDR_W-1:0]   ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // combinational helpers
  logic [CNT_W-1:0]     managed;
  logic [CNT_W-1:0]     nwords_sum;
  logic [ADDR_W-1:0]    diff;
  logic [SIZE_W:0]      size_round;
  logic [FIDX_W:0]      end_sum;
  logic [CNT_W-1:0]     hi_calc;
  logic                 idx_past;
  logic [WADDR_W-1:0]   idx_word;
  logic [WORD_BITS-1:0] avail;
  logic [BIT_W-1:0]     pos;
  logic                 issue;
  logic [WORD_BITS-1:0] lo_mask;
  logic [CNT_W-1:0]     next_word_base;
  logic                 fin;
  logic                 fin_alloc;
  logic [STATUS_W-1:0]  fin_status;

  // a frame count above the map capacity counts as the capacity
  assign managed = (32'(frame_limit) > MAX_FRAMES) ? CNT_W'(MAX_FRAMES) : CNT_W'(frame_limit);
  assign nwords_sum = managed + CNT_W'(WORD_BITS - 1);
  assign diff = addr_q - base_address;
  assign size_round = {1'b0, size_q} + (SIZE_W + 1)'(PAGE_BYTES - 1);

  assign idx_past = idx_q >= FIDX_W'(cnt_q);
  assign end_sum  = {1'b0, idx_q} + (FIDX_W + 1)'(n_q);
  assign hi_calc  = (end_sum < (FIDX_W + 1)'(cnt_q)) ? CNT_W'(end_sum) : cnt_q;
  assign idx_word = idx_q[BIT_W +: WADDR_W];

  // free bits of the word just read, within the managed frames
  assign avail = ~ram_rdata & upper_mask(chk_word, cnt_q);
  assign issue = rd_ptr < nwords_q;

  always_comb begin
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pos = BIT_W'(b);
      end
    end
  end

  assign lo_mask = (wptr == lo_q[BIT_W +: WADDR_W]) ?
                   ({WORD_BITS{1'b1}} << lo_q[BIT_W-1:0]) : '1;
  assign next_word_base = CNT_W'({(WADDR_W + 1)'(wptr) + (WADDR_W + 1)'(1), BIT_W'(0)});

  assign busy = (state != S_IDLE);

  bfa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // next state, ram controls and result selection
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = wptr;
    ram_wdata  = '0;
    ram_raddr  = idx_word;
    fin        = 1'b0;
    fin_alloc  = 1'b0;
    fin_status = ST_DONE;

    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_PREP;
        end
      end

      S_PREP: begin
        state_next = S_DECIDE;
      end

      S_DECIDE: begin
        unique case (act_q)
          ACT_ALLOC: begin
            if (nwords_q == '0) begin
              fin        = 1'b1;
              fin_status = ST_OOM;
              state_next = S_IDLE;
            end else begin
              state_next = S_SCAN;
            end
          end
          ACT_FREE: begin
            // read of the target word goes out now
            if (below_q || misalign_q || idx_past) begin
              fin        = 1'b1;
              fin_status = ST_IGNORED;
              state_next = S_IDLE;
            end else begin
              state_next = S_FREE_WR;
            end
          end
          ACT_MARK: begin
            if (below_q) begin
              fin        = 1'b1;
              fin_status = ST_IGNORED;
              state_next = S_IDLE;
            end else if (n_q == '0 || idx_past) begin
              fin        = 1'b1;
              state_next = S_IDLE;
            end else begin
              state_next = S_MARK_RD;
            end
          end
          ACT_INIT: begin
            state_next = S_FILL;
          end
          default: begin
            state_next = S_IDLE;
          end
        endcase
      end

      S_SCAN: begin
        // reads run one word ahead of the check
        ram_raddr = rd_ptr[WADDR_W-1:0];
        if (rd_valid && avail != '0) begin
          ram_we     = 1'b1;
          ram_waddr  = chk_word;
          ram_wdata  = ram_rdata | (WORD_BITS'(1) << pos);
          state_next = S_ALLOC_FIN;
        end else if (rd_valid && (LW_W'(chk_word) + LW_W'(1) == nwords_q)) begin
          fin        = 1'b1;
          fin_status = ST_OOM;
          state_next = S_IDLE;
        end
      end

      S_ALLOC_FIN: begin
        fin        = 1'b1;
        fin_alloc  = 1'b1;
        state_next = S_IDLE;
      end

      S_FREE_WR: begin
        ram_we     = 1'b1;
        ram_waddr  = idx_word;
        ram_wdata  = ram_rdata & ~(WORD_BITS'(1) << idx_q[BIT_W-1:0]);
        fin        = 1'b1;
        state_next = S_IDLE;
      end

      S_MARK_RD: begin
        ram_raddr  = wptr;
        state_next = S_MARK_WR;
      end

      S_MARK_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata | (lo_mask & upper_mask(wptr, hi_q));
        if (next_word_base >= hi_q) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_MARK_RD;
        end
      end

      S_FILL: begin
        // frames below the count free, the rest used; the reset pass uses a count of zero
        ram_we    = 1'b1;
        ram_wdata = ~upper_mask(wptr, fill_reset ? '0 : cnt_q);
        if (wptr == WADDR_W'(MAP_WORDS - 1)) begin
          fin        = !fill_reset;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= BASE_RESET;
      frame_limit  <= '0;
    end else if (write_enable) begin
      if (write_index == REG_BASE_ADDRESS) begin
        base_address <= write_data;
      end else if (write_index == REG_FRAME_COUNT) begin
        frame_limit <= write_data[COUNT_W-1:0];
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_FILL;
      fill_reset <= 1'b1;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
      if (state == S_DECIDE) begin
        fill_reset <= 1'b0;
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (fin) begin
      status        <= fin_status;
      frame_address <= fin_alloc ?
                       base_address + ADDR_W'({hit_idx, PAGE_SH'(0)}) : '0;
    end
  end

  // request capture, operand preparation and walkers
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr     <= '0;
      rd_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act_q  <= action;
            addr_q <= address;
            size_q <= size_bytes;
          end
        end

        S_PREP: begin
          cnt_q      <= managed;
          nwords_q   <= nwords_sum[CNT_W-1:BIT_W];
          below_q    <= addr_q < base_address;
          misalign_q <= addr_q[PAGE_SH-1:0] != '0;
          idx_q      <= diff[ADDR_W-1:PAGE_SH];
          n_q        <= size_round[SIZE_W:PAGE_SH];
        end

        S_DECIDE: begin
          rd_ptr   <= '0;
          rd_valid <= 1'b0;
          lo_q     <= idx_q[CNT_W-1:0];
          hi_q     <= hi_calc;
          if (act_q == ACT_INIT) begin
            wptr <= '0;
          end else begin
            wptr <= idx_word;
          end
        end

        S_SCAN: begin
          rd_valid <= issue;
          chk_word <= rd_ptr[WADDR_W-1:0];
          if (issue) begin
            rd_ptr <= rd_ptr + LW_W'(1);
          end
          if (rd_valid && avail != '0) begin
            hit_idx <= {chk_word, pos};
          end
        end

        S_MARK_WR: begin
          wptr <= wptr + WADDR_W'(1);
        end

        S_FILL: begin
          wptr <= wptr + WADDR_W'(1);
        end

        S_ALLOC_FIN, S_FREE_WR, S_MARK_RD: begin
          rd_valid <= 1'b0;
        end

        default: begin
          rd_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule
